[design/scl_pkg.sv]
// Package for the station credit ledger: table size, command and status codes,
// and the word and token types shared by the cell row and the controller.
// Depends on nothing.
package scl_pkg;

	// Number of table entries, one cell each.
	localparam int STATIONS = 16;
	localparam int IDX_W    = (STATIONS > 1) ? $clog2(STATIONS) : 1;

	// Command codes; code 3 behaves as a query.
	localparam logic [1:0] CMD_NONCE = 2'd0;
	localparam logic [1:0] CMD_SET   = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	// Result status codes.
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_MISS = 2'd2;

	// Request word.
	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] station_key;
		logic [63:0] new_balance;
		logic [31:0] new_rate;
	} scl_in_t;

	// Result word.
	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  slot;
		logic [63:0] balance_out;
		logic [31:0] rate_out;
		logic [31:0] accepted_out;
		logic        has_credit;
		logic [31:0] relayed_total;
		logic [31:0] issued_total;
	} scl_out_t;

	// Token that walks the cell row. In the search pass it gathers the
	// matching entry and the first free entry; in the update pass it carries
	// the target index and comes back with the entry contents.
	typedef struct packed {
		logic             vld;
		logic             phase;     // 0 search, 1 update
		logic [1:0]       cmd;
		logic [31:0]      key;
		logic [63:0]      bal;
		logic [31:0]      rate;
		logic [31:0]      acc;
		logic             hit;
		logic [IDX_W-1:0] hit_idx;   // target index in the update pass
		logic             free;
		logic [IDX_W-1:0] free_idx;
		logic             alloc;
		logic [IDX_W-1:0] pos;
	} scl_tok_t;

endpackage

[design/scl_cell.sv]
// One ledger cell: holds a single table entry and passes the command token on
// to its neighbor every cycle, searching or updating on the way.
// Depends on scl_pkg.
module scl_cell import scl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  scl_tok_t tin,
	output scl_tok_t tout
);

	logic        valid_q;
	logic [31:0] key_q;
	logic [63:0] bal_q;
	logic [31:0] rate_q;
	logic [31:0] acc_q;

	scl_tok_t tok_q;
	logic     vld_q;
	scl_tok_t tok_nxt;

	logic        match;
	logic        target;
	logic [63:0] base_bal;
	logic [31:0] base_rate;
	logic [31:0] base_acc;
	logic [63:0] new_bal;
	logic [31:0] new_rate;
	logic [31:0] new_acc;

	assign match  = valid_q && (key_q == tin.key);
	assign target = tin.vld && tin.phase && (tin.pos == tin.hit_idx);

	// Starting contents: a fresh entry when allocating, else the stored one.
	// For a nonce the token's rate field holds the default reward.
	assign base_bal  = tin.alloc ? 64'd0 : bal_q;
	assign base_rate = tin.alloc ? tin.rate : rate_q;
	assign base_acc  = tin.alloc ? 32'd0 : acc_q;

	// Apply the command to the entry.
	always_comb begin
		new_bal  = base_bal;
		new_rate = base_rate;
		new_acc  = base_acc;
		case (tin.cmd)
			CMD_NONCE: begin
				new_bal = base_bal + {32'd0, base_rate};
				new_acc = base_acc + 32'd1;
			end
			CMD_SET: begin
				new_bal  = tin.bal;
				new_rate = tin.rate;
			end
			default: begin
			end
		endcase
	end

	// Token seen by the next cell.
	always_comb begin
		tok_nxt     = tin;
		tok_nxt.pos = tin.pos + IDX_W'(1);
		if (tin.vld && !tin.phase) begin
			if (match && !tin.hit) begin
				tok_nxt.hit     = 1'b1;
				tok_nxt.hit_idx = tin.pos;
			end
			if (!valid_q && !tin.free) begin
				tok_nxt.free     = 1'b1;
				tok_nxt.free_idx = tin.pos;
			end
		end
		if (target) begin
			tok_nxt.bal  = new_bal;
			tok_nxt.rate = new_rate;
			tok_nxt.acc  = new_acc;
		end
	end

	// Token valid bit and entry valid mark.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			vld_q <= tin.vld;
			if (target) begin
				valid_q <= 1'b1;
			end
		end
	end

	// Token payload and entry contents.
	always_ff @(posedge clk) begin
		tok_q <= tok_nxt;
		if (target) begin
			key_q  <= tin.key;
			bal_q  <= new_bal;
			rate_q <= new_rate;
			acc_q  <= new_acc;
		end
	end

	always_comb begin
		tout     = tok_q;
		tout.vld = vld_q;
	end

endmodule

[design/station_credit_ledger.sv]
// Station credit ledger: a row of STATIONS cells, one table entry each.
// Each request walks the token through the cell row: a search pass, then an update
// pass when an entry is found or allocated; on table full or query miss only the
// search pass runs. A new request is taken only after the result of the last one
// has loaded the output register (req_stall is high outside idle).
// Reset clears all entry valid marks and counters at once; default reward is 1.
module station_credit_ledger import scl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  scl_in_t     req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output scl_out_t    rsp,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t      state_q;
	logic [31:0] reward_q;
	logic [31:0] relayed_q;
	logic [31:0] issued_q;
	scl_out_t    res_q;
	scl_out_t    rsp_q;
	logic        rsp_valid_q;

	scl_tok_t tok [STATIONS+1];
	scl_tok_t chain_in;
	scl_tok_t tend;

	logic             is_nonce;
	logic             is_set;
	logic             apply;
	logic             search_end;
	logic             update_end;
	logic             out_free;
	logic [31:0]      relayed_nxt;

	assign tend       = tok[STATIONS];
	assign is_nonce   = (tend.cmd == CMD_NONCE);
	assign is_set     = (tend.cmd == CMD_SET);
	assign apply      = tend.hit || (tend.free && (is_nonce || is_set));
	assign search_end = (state_q == S_RUN) && tend.vld && !tend.phase;
	assign update_end = (state_q == S_RUN) && tend.vld && tend.phase;
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign relayed_nxt = is_nonce ? relayed_q + 32'd1 : relayed_q;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Token entering the first cell: a new request, or the update pass.
	always_comb begin
		chain_in = tend;
		chain_in.vld = 1'b0;
		if ((state_q == S_IDLE) && req_valid) begin
			chain_in.vld      = 1'b1;
			chain_in.phase    = 1'b0;
			chain_in.cmd      = req.cmd;
			chain_in.key      = req.station_key;
			chain_in.bal      = req.new_balance;
			chain_in.rate     = req.new_rate;
			chain_in.acc      = 32'd0;
			chain_in.hit      = 1'b0;
			chain_in.hit_idx  = '0;
			chain_in.free     = 1'b0;
			chain_in.free_idx = '0;
			chain_in.alloc    = 1'b0;
			chain_in.pos      = '0;
		end else if (search_end && apply) begin
			chain_in.vld     = 1'b1;
			chain_in.phase   = 1'b1;
			chain_in.alloc   = !tend.hit;
			chain_in.hit_idx = tend.hit ? tend.hit_idx : tend.free_idx;
			chain_in.pos     = '0;
			if (is_nonce) begin
				chain_in.rate = reward_q;
			end
		end
	end

	assign tok[0] = chain_in;

	// The cell row.
	for (genvar g = 0; g < STATIONS; g++) begin : g_cell
		scl_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tin    (tok[g]),
			.tout   (tok[g+1])
		);
	end

	// Sequencer, counters, configuration and output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			reward_q    <= 32'd1;
			relayed_q   <= 32'd0;
			issued_q    <= 32'd0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				reward_q <= cfg_wdata;
			end
			// A finished result loads the output register; otherwise an accepted one leaves it.
			if ((state_q == S_DONE) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (search_end) begin
						relayed_q <= relayed_nxt;
						if (apply) begin
							if (is_nonce) begin
								issued_q <= issued_q + 32'd1;
							end
						end else begin
							state_q <= S_DONE;
						end
					end else if (update_end) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result staging and output word.
	always_ff @(posedge clk) begin
		if (search_end && !apply) begin
			res_q.status        <= (is_nonce || is_set) ? STAT_FULL : STAT_MISS;
			res_q.slot          <= 4'd0;
			res_q.balance_out   <= 64'd0;
			res_q.rate_out      <= 32'd0;
			res_q.accepted_out  <= 32'd0;
			res_q.has_credit    <= 1'b0;
			res_q.relayed_total <= relayed_nxt;
			res_q.issued_total  <= issued_q;
		end else if (update_end) begin
			res_q.status        <= STAT_OK;
			res_q.slot          <= 4'(tend.hit_idx);
			res_q.balance_out   <= tend.bal;
			res_q.rate_out      <= tend.rate;
			res_q.accepted_out  <= tend.acc;
			res_q.has_credit    <= (tend.bal != 64'd0);
			res_q.relayed_total <= relayed_q;
			res_q.issued_total  <= issued_q;
		end
		if ((state_q == S_DONE) && out_free) begin
			rsp_q <= res_q;
		end
	end

endmodule

[bench/testbench.sv]
// Self-checking bench for station_credit_ledger: drives request words, predicts every
// result word from its own copy of the credit table, and compares them in order.
// Depends on scl_pkg and the station_credit_ledger RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import scl_pkg::*;

	// The spare command code must behave as a query.
	localparam logic [1:0] CMD_SPARE = 2'd3;
	// One full search and update pass, plus margin.
	localparam int PASS_CYCLES = 2 * STATIONS + 4;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	scl_in_t  req = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	scl_out_t rsp;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;

	// Request words waiting to be sent, and result words predicted for accepted requests.
	scl_in_t  pending_words [$];
	scl_out_t expected_rsp [$];
	logic [31:0] key_pool [$];

	int send_idle_pct = 35;
	int rsp_idle_pct  = 79;
	int results_seen  = 0;
	int hold_left     = 0;
	int errors        = 0;

	// Predicted ledger contents.
	bit          led_valid [STATIONS];
	bit [31:0]   led_key [STATIONS];
	bit [63:0]   led_balance [STATIONS];
	bit [31:0]   led_rate [STATIONS];
	bit [31:0]   led_accepted [STATIONS];
	bit [31:0]   relayed_cnt = '0;
	bit [31:0]   issued_cnt = '0;
	bit [31:0]   cur_reward = 32'd1;

	station_credit_ledger u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	// Apply one request word to the predicted ledger and return the result word it yields.
	function automatic scl_out_t apply_to_ledger(input scl_in_t w);
		scl_out_t r;
		int       slot_idx;
		bit       may_alloc;
		r = '0;
		slot_idx = -1;
		may_alloc = (w.cmd == CMD_NONCE) || (w.cmd == CMD_SET);
		// Lowest-indexed valid entry with a matching key wins.
		for (int i = STATIONS - 1; i >= 0; i--) begin
			if (led_valid[i] && led_key[i] == w.station_key)
				slot_idx = i;
		end
		// On a miss, nonce and set claim the lowest free entry.
		if (slot_idx < 0 && may_alloc) begin
			for (int i = STATIONS - 1; i >= 0; i--) begin
				if (!led_valid[i])
					slot_idx = i;
			end
			if (slot_idx >= 0) begin
				led_valid[slot_idx]    = 1'b1;
				led_key[slot_idx]      = w.station_key;
				led_balance[slot_idx]  = '0;
				led_rate[slot_idx]     = cur_reward;
				led_accepted[slot_idx] = '0;
			end
		end
		if (w.cmd == CMD_NONCE) begin
			relayed_cnt = relayed_cnt + 32'd1;
			if (slot_idx >= 0) begin
				led_balance[slot_idx]  = led_balance[slot_idx] + {32'd0, led_rate[slot_idx]};
				led_accepted[slot_idx] = led_accepted[slot_idx] + 32'd1;
				issued_cnt = issued_cnt + 32'd1;
			end
		end else if (w.cmd == CMD_SET && slot_idx >= 0) begin
			led_balance[slot_idx] = w.new_balance;
			led_rate[slot_idx]    = w.new_rate;
		end
		// Full and miss results carry no entry contents.
		if (slot_idx >= 0) begin
			r.status       = STAT_OK;
			r.slot         = slot_idx[3:0];
			r.balance_out  = led_balance[slot_idx];
			r.rate_out     = led_rate[slot_idx];
			r.accepted_out = led_accepted[slot_idx];
			r.has_credit   = (led_balance[slot_idx] != 64'd0);
		end else begin
			r.status = may_alloc ? STAT_FULL : STAT_MISS;
		end
		r.relayed_total = relayed_cnt;
		r.issued_total  = issued_cnt;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp_v,
		input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// Driver: offers the next pending word, holds it while stalled, predicts on acceptance.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || !req_stall) begin
			if (req_valid)
				expected_rsp.push_back(apply_to_ledger(req));
			if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				req_valid <= 1'b1;
				req <= pending_words.pop_front();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Monitor: checks each accepted result word and drives the random stall.
	// After the 40th and the 520th result it holds off for a long stretch.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				results_seen++;
				if (expected_rsp.size() == 0) begin
					$display("%0t ns: result word with none expected, actual %h", $time, rsp);
					errors++;
				end else begin
					scl_out_t e;
					e = expected_rsp.pop_front();
					check_field("status", e.status, rsp.status);
					check_field("slot", e.slot, rsp.slot);
					check_field("balance_out", e.balance_out, rsp.balance_out);
					check_field("rate_out", e.rate_out, rsp.rate_out);
					check_field("accepted_out", e.accepted_out, rsp.accepted_out);
					check_field("has_credit", e.has_credit, rsp.has_credit);
					check_field("relayed_total", e.relayed_total, rsp.relayed_total);
					check_field("issued_total", e.issued_total, rsp.issued_total);
				end
				if (results_seen == 40 || results_seen == 520)
					hold_left = 300;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
			end
		end
	end

	task automatic queue_word(input logic [1:0] cmd, input logic [31:0] key,
		input logic [63:0] bal, input logic [31:0] rate);
		scl_in_t w;
		w.cmd         = cmd;
		w.station_key = key;
		w.new_balance = bal;
		w.new_rate    = rate;
		pending_words.push_back(w);
	endtask

	// Wait until every queued word is sent and every expected result has arrived.
	task automatic wait_drained();
		while (pending_words.size() != 0 || req_valid || expected_rsp.size() != 0)
			@(posedge clk);
	endtask

	// The register is written only while the block is idle.
	task automatic write_reward(input logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		cur_reward = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random words, mostly aimed at known stations so that hits dominate.
	task automatic run_random(input int count, input int send_pct, input int recv_pct);
		logic [1:0]  cmd;
		logic [31:0] key;
		logic [63:0] bal;
		logic [31:0] rate;
		int          pick;
		send_idle_pct = send_pct;
		rsp_idle_pct  = recv_pct;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(9);
			if (pick < 5)
				cmd = CMD_NONCE;
			else if (pick < 7)
				cmd = CMD_SET;
			else if (pick < 9)
				cmd = CMD_QUERY;
			else
				cmd = CMD_SPARE;
			if ($urandom_range(3) != 0)
				key = key_pool[$urandom_range(key_pool.size() - 1)];
			else
				key = $urandom;
			case ($urandom_range(3))
				0: bal = '0;
				1: bal = {32'hFFFF_FFFF, 32'($urandom)};
				default: bal = {32'($urandom), 32'($urandom)};
			endcase
			rate = ($urandom_range(4) == 0) ? 32'hFFFF_FFFF : 32'($urandom);
			queue_word(cmd, key, bal, rate);
		end
		wait_drained();
	endtask

	// Reset, directed words across reward settings, then three random phases.
	initial begin
		logic [31:0] k;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset reward of one: misses on an empty table, then a first entry.
		queue_word(CMD_QUERY, 32'h0, '0, '0);
		queue_word(CMD_SPARE, 32'hFFFF_FFFF, '1, '1);
		queue_word(CMD_NONCE, 32'h0, '1, '1);
		queue_word(CMD_NONCE, 32'h0, '0, '0);
		queue_word(CMD_QUERY, 32'h0, '0, '0);
		queue_word(CMD_SPARE, 32'h0, '0, '0);
		key_pool.push_back(32'h0);
		wait_drained();

		// Zero reward: an entry without credit, then a balance that wraps.
		write_reward(32'h0);
		queue_word(CMD_NONCE, 32'hFFFF_FFFF, '0, '0);
		queue_word(CMD_QUERY, 32'hFFFF_FFFF, '0, '0);
		queue_word(CMD_SET, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		queue_word(CMD_NONCE, 32'hFFFF_FFFF, '0, '0);
		key_pool.push_back(32'hFFFF_FFFF);
		wait_drained();

		// Largest reward: allocation by a set word and by a nonce word.
		write_reward(32'hFFFF_FFFF);
		queue_word(CMD_SET, 32'h5A5A_A5A5, '0, '0);
		queue_word(CMD_NONCE, 32'hA5A5_5A5A, '0, '0);
		key_pool.push_back(32'h5A5A_A5A5);
		key_pool.push_back(32'hA5A5_5A5A);
		wait_drained();

		// Random reward: fill the table, then hit the full and miss cases.
		write_reward($urandom);
		for (int i = 4; i < STATIONS; i++) begin
			k = $urandom;
			key_pool.push_back(k);
			queue_word(CMD_NONCE, k, {32'($urandom), 32'($urandom)}, $urandom);
		end
		k = $urandom;
		queue_word(CMD_NONCE, k, '0, '0);
		queue_word(CMD_SET, k, '1, '1);
		queue_word(CMD_QUERY, k, '0, '0);
		wait_drained();

		run_random(330, 35, 79);
		write_reward($urandom);
		run_random(330, 79, 35);
		write_reward(32'd1);
		run_random(340, 0, 0);

		repeat (PASS_CYCLES) @(posedge clk);
		if (errors == 0 && expected_rsp.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#6_000_000;
		$display("testbench: errors");
		$finish;
	end

endmodule
